[rtl/sorted_priority_queue_macros.svh]
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spq_pkg.sv]
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned IN_TAG_W  = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ENTRIES_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_LIST    = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

[rtl/spq_if.sv]
// Command and result channel interfaces of the sorted priority queue.
interface spq_cmd_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_W-1:0]    key;
  logic [IN_TAG_W-1:0] name_tag;

  modport source (output valid, command, key, name_tag, input ready);
  modport sink (input valid, command, key, name_tag, output ready);
endinterface

interface spq_res_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [KEY_W-1:0]     out_key;
  logic [IN_TAG_W-1:0]  out_tag;
  logic [ENTRIES_W-1:0] entries;
  logic                 last;

  modport source (output valid, status, out_key, out_tag, entries, last, input ready);
  modport sink (input valid, status, out_key, out_tag, entries, last, output ready);
endinterface

[rtl/spq_cell.sv]
// One slot of the sorted entry chain, exchanging its entry with its neighbors.
module spq_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned TAG_WIDTH = 16,
  parameter int unsigned CNT_W     = 5
) (
  input  logic                     clk_i,
  input  spq_pkg::cell_ctl_t       ctl_i,
  input  logic [TAG_WIDTH-1:0]     tag_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [spq_pkg::KEY_W-1:0] left_key_i,
  input  logic [TAG_WIDTH-1:0]     left_tag_i,
  input  logic                     left_ins_i,
  input  logic [spq_pkg::KEY_W-1:0] right_key_i,
  input  logic [TAG_WIDTH-1:0]     right_tag_i,
  input  logic [spq_pkg::KEY_W-1:0] head_key_i,
  input  logic [TAG_WIDTH-1:0]     head_tag_i,
  output logic [spq_pkg::KEY_W-1:0] key_o,
  output logic [TAG_WIDTH-1:0]     tag_o,
  output logic                     ins_o
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] IdxC  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] TailC = CNT_W'(IDX + 1);

  logic [KEY_W-1:0]     key_q, key_d;
  logic [TAG_WIDTH-1:0] tag_q, tag_d;
  logic                 occupied;

  // The new entry goes in front of every held key that is strictly larger.
  assign occupied = IdxC < count_i;
  assign ins_o    = !occupied || (key_q > ctl_i.key);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (ins_o) begin
          if (left_ins_i) begin
            key_d = left_key_i;
            tag_d = left_tag_i;
          end else begin
            key_d = ctl_i.key;
            tag_d = tag_i;
          end
        end
      end
      OP_SHIFT: begin
        key_d = right_key_i;
        tag_d = right_tag_i;
      end
      OP_ROTATE: begin
        if (count_i == TailC) begin
          key_d = head_key_i;
          tag_d = head_tag_i;
        end else begin
          key_d = right_key_i;
          tag_d = right_tag_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;
endmodule

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: control, fill count, result register and cell chain.
//
// Channel   Direction  Transfer carries
// in_i      sink       command, key, name_tag
// out_o     source     status, out_key, out_tag, entries, last
//
// Enqueue and dequeue each give one result; a result sits in the output register
// and the next command is taken in the cycle it leaves.
// List first loads its entry counter and then gives one result per held entry, the chain
// rotating by one slot for every result; no command is taken meanwhile.
// A stalled output holds the result register and the chain.
// Reset clears the fill count, the control state and the output valid.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_cmd_if.sink   in_i,
  spq_res_if.source out_o
);
  import spq_pkg::*;

  localparam int unsigned     CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] OneC   = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     remain_q, remain_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [KEY_W-1:0]     out_key_q, out_key_d;
  logic [IN_TAG_W-1:0]  out_tag_q, out_tag_d;
  logic [ENTRIES_W-1:0] entries_q, entries_d;
  logic                 last_q, last_d;

  logic                 in_ready, accept, out_free, full, empty;
  logic [TAG_WIDTH-1:0] new_tag;
  cell_ctl_t            ctl;

  logic [KEY_W-1:0]     cell_key [DEPTH];
  logic [TAG_WIDTH-1:0] cell_tag [DEPTH];
  logic [DEPTH-1:0]     cell_ins;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_ready;
  assign full     = count_q == DepthC;
  assign empty    = count_q == '0;
  assign new_tag  = TAG_WIDTH'(in_i.name_tag);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    out_key_d   = out_key_q;
    out_tag_d   = out_tag_q;
    entries_d   = entries_q;
    last_d      = last_q;
    ctl.op      = OP_HOLD;
    ctl.key     = in_i.key;

    if (accept) begin
      case (cmd_e'(in_i.command))
        CMD_ENQUEUE: begin
          out_valid_d = 1'b1;
          out_key_d   = in_i.key;
          out_tag_d   = IN_TAG_W'(new_tag);
          last_d      = 1'b1;
          if (full) begin
            status_d  = STATUS_FULL;
            entries_d = ENTRIES_W'(count_q);
          end else begin
            ctl.op    = OP_INSERT;
            count_d   = count_q + OneC;
            status_d  = STATUS_OK;
            entries_d = ENTRIES_W'(count_q + OneC);
          end
        end
        CMD_DEQUEUE: begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          if (empty) begin
            status_d  = STATUS_EMPTY;
            out_key_d = '0;
            out_tag_d = '0;
            entries_d = '0;
          end else begin
            ctl.op    = OP_SHIFT;
            count_d   = count_q - OneC;
            status_d  = STATUS_OK;
            out_key_d = cell_key[0];
            out_tag_d = IN_TAG_W'(cell_tag[0]);
            entries_d = ENTRIES_W'(count_q - OneC);
          end
        end
        CMD_LIST: begin
          if (empty) begin
            out_valid_d = 1'b1;
            status_d    = STATUS_EMPTY;
            out_key_d   = '0;
            out_tag_d   = '0;
            entries_d   = '0;
            last_d      = 1'b1;
          end else begin
            state_d  = ST_LIST;
            remain_d = count_q;
          end
        end
        default: begin
        end
      endcase
    end else if (state_q == ST_LIST && out_free) begin
      ctl.op      = OP_ROTATE;
      out_valid_d = 1'b1;
      status_d    = STATUS_OK;
      out_key_d   = cell_key[0];
      out_tag_d   = IN_TAG_W'(cell_tag[0]);
      entries_d   = ENTRIES_W'(count_q);
      last_d      = remain_q == OneC;
      remain_d    = remain_q - OneC;
      if (remain_q == OneC) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    out_key_q <= out_key_d;
    out_tag_q <= out_tag_d;
    entries_q <= entries_d;
    last_q    <= last_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]     left_key, right_key;
    logic [TAG_WIDTH-1:0] left_tag, right_tag;
    logic                 left_ins;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_tag = '0;
      assign left_ins = 1'b0;
    end else begin : g_inner_left
      assign left_key = cell_key[i-1];
      assign left_tag = cell_tag[i-1];
      assign left_ins = cell_ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_final
      assign right_key = '0;
      assign right_tag = '0;
    end else begin : g_inner_right
      assign right_key = cell_key[i+1];
      assign right_tag = cell_tag[i+1];
    end

    spq_cell #(
      .IDX       (i),
      .TAG_WIDTH (TAG_WIDTH),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .tag_i       (new_tag),
      .count_i     (count_q),
      .left_key_i  (left_key),
      .left_tag_i  (left_tag),
      .left_ins_i  (left_ins),
      .right_key_i (right_key),
      .right_tag_i (right_tag),
      .head_key_i  (cell_key[0]),
      .head_tag_i  (cell_tag[0]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i]),
      .ins_o       (cell_ins[i])
    );
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.status  = status_q;
  assign out_o.out_key = out_key_q;
  assign out_o.out_tag = out_tag_q;
  assign out_o.entries = entries_q;
  assign out_o.last    = last_q;

  `SPQ_ASSERT_SAME(a_count_bounded, 1'b1, count_q <= DepthC, "Fill count exceeds the depth.")
  `SPQ_ASSERT_SAME(a_list_blocks_input, state_q == ST_LIST, !in_ready, "Command taken during a list.")
  `SPQ_ASSERT_SAME(a_list_remain, state_q == ST_LIST, (remain_q != '0) && (remain_q <= count_q), "List counter out of range.")
  `SPQ_ASSERT_NEXT(a_enqueue_grows, accept && (in_i.command == CMD_ENQUEUE) && !full, count_q == $past(count_q) + OneC, "Enqueue did not grow the queue.")
  `SPQ_ASSERT_NEXT(a_dequeue_shrinks, accept && (in_i.command == CMD_DEQUEUE) && !empty, count_q == $past(count_q) - OneC, "Dequeue did not shrink the queue.")
endmodule

[tb/sorted_priority_queue_tb.sv]
// Self-checking testbench of the sorted priority queue with a driver, a monitor and a watchdog.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned TAG_WIDTH    = 16;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned SETTLE       = 20;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [KEY_W-1:0]    key;
    logic [IN_TAG_W-1:0] name_tag;
    bit                  pause;
  } request_t;

  typedef struct {
    status_e              status;
    logic [KEY_W-1:0]     key;
    logic [IN_TAG_W-1:0]  tag;
    logic [ENTRIES_W-1:0] entries;
    logic                 last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_cmd_if cmd_ch ();
  spq_res_if res_ch ();

  sorted_priority_queue #(
    .DEPTH    (DEPTH),
    .TAG_WIDTH(TAG_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .out_o (res_ch)
  );

  always #10 clk_i = ~clk_i;

  request_t requests[$];
  result_t  awaited[$];

  logic [KEY_W-1:0]     held_key[DEPTH];
  logic [TAG_WIDTH-1:0] held_tag[DEPTH];
  int unsigned          held_count = 0;
  int unsigned          max_held = 0;

  int unsigned errors = 0;
  int unsigned n_enqueue = 0;
  int unsigned n_reject = 0;
  int unsigned n_dequeue = 0;
  int unsigned n_list = 0;
  int unsigned n_ignored = 0;
  int unsigned n_results = 0;

  bit          pausing = 1'b0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  task automatic add_request(logic [CMD_W-1:0] command, logic [KEY_W-1:0] key,
                             logic [IN_TAG_W-1:0] name_tag);
    request_t req;
    req.command  = command;
    req.key      = key;
    req.name_tag = name_tag;
    req.pause    = 1'b0;
    requests.push_back(req);
  endtask

  task automatic add_pause();
    request_t req;
    req.command  = CMD_UNUSED;
    req.key      = '0;
    req.name_tag = '0;
    req.pause    = 1'b1;
    requests.push_back(req);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] key;
    case ($urandom_range(0, 3))
      0, 1: key = $urandom;
      2: key = $urandom_range(0, 15);
      default: begin
        case ($urandom_range(0, 3))
          0: key = '0;
          1: key = '1;
          2: key = 32'h7FFF_FFFF;
          default: key = 32'h8000_0000;
        endcase
      end
    endcase
    return key;
  endfunction

  function automatic void await_result(status_e status, logic [KEY_W-1:0] key,
                                       logic [IN_TAG_W-1:0] tag, int unsigned count,
                                       logic last);
    result_t res;
    res.status  = status;
    res.key     = key;
    res.tag     = tag;
    res.entries = ENTRIES_W'(count);
    res.last    = last;
    awaited.push_back(res);
  endfunction

  // Updates the queue image for one accepted command and records the results it causes.
  function automatic void apply_command(logic [CMD_W-1:0] command, logic [KEY_W-1:0] key,
                                        logic [IN_TAG_W-1:0] name_tag);
    logic [TAG_WIDTH-1:0] tag;
    int                   pos;
    tag = name_tag[TAG_WIDTH-1:0];
    case (command)
      CMD_ENQUEUE: begin
        n_enqueue++;
        if (held_count >= DEPTH) begin
          n_reject++;
          await_result(STATUS_FULL, key, IN_TAG_W'(tag), held_count, 1'b1);
        end else begin
          pos = 0;
          while (pos < int'(held_count) && held_key[pos] <= key) pos++;
          for (int i = int'(held_count); i > pos; i--) begin
            held_key[i] = held_key[i-1];
            held_tag[i] = held_tag[i-1];
          end
          held_key[pos] = key;
          held_tag[pos] = tag;
          held_count++;
          if (held_count > max_held) max_held = held_count;
          await_result(STATUS_OK, key, IN_TAG_W'(tag), held_count, 1'b1);
        end
      end
      CMD_DEQUEUE: begin
        n_dequeue++;
        if (held_count == 0) begin
          await_result(STATUS_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          await_result(STATUS_OK, held_key[0], IN_TAG_W'(held_tag[0]), held_count - 1, 1'b1);
          for (int i = 1; i < int'(held_count); i++) begin
            held_key[i-1] = held_key[i];
            held_tag[i-1] = held_tag[i];
          end
          held_count--;
        end
      end
      CMD_LIST: begin
        n_list++;
        if (held_count == 0) begin
          await_result(STATUS_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < int'(held_count); i++) begin
            await_result(STATUS_OK, held_key[i], IN_TAG_W'(held_tag[i]), held_count,
                         i == int'(held_count) - 1);
          end
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    request_t req;
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else if (!(cmd_ch.valid && !cmd_ch.ready)) begin
      if (cmd_ch.valid) begin
        apply_command(cmd_ch.command, cmd_ch.key, cmd_ch.name_tag);
        if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 9);
      end
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (pausing) begin
        if (awaited.size() == 0) pausing = 1'b0;
        cmd_ch.valid <= 1'b0;
      end else if (requests.size() > 0) begin
        req = requests.pop_front();
        if (req.pause) begin
          pausing = 1'b1;
          cmd_ch.valid <= 1'b0;
        end else begin
          cmd_ch.command  <= req.command;
          cmd_ch.key      <= req.key;
          cmd_ch.name_tag <= req.name_tag;
          cmd_ch.valid    <= 1'b1;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    logic    ready_next;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_results++;
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual key %0h tag %0h",
                   $time, res_ch.out_key, res_ch.out_tag);
        end else begin
          want = awaited.pop_front();
          check_field("status", 32'(want.status), 32'(res_ch.status));
          check_field("out_key", want.key, res_ch.out_key);
          check_field("out_tag", 32'(want.tag), 32'(res_ch.out_tag));
          check_field("entries", 32'(want.entries), 32'(res_ch.entries));
          check_field("last", 32'(want.last), 32'(res_ch.last));
        end
        if (n_results == 80 || n_results == 500) hold_left = LONG_HOLD;
        if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
        take_gap = take_burst ? 0 : $urandom_range(0, 9);
      end
      ready_next = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        ready_next = 1'b0;
      end
      res_ch.ready <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned      lean;
    int unsigned      roll;
    int unsigned      enq_share;
    logic [CMD_W-1:0] command;

    rst_ni          = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.command  = CMD_ENQUEUE;
    cmd_ch.key      = '0;
    cmd_ch.name_tag = '0;
    res_ch.ready    = 1'b0;

    // Empty queue, then the extremes, equal keys, a full queue and a rejected entry.
    add_request(CMD_LIST, '0, '0);
    add_request(CMD_DEQUEUE, '0, '0);
    add_request(CMD_UNUSED, '1, '1);
    add_request(CMD_ENQUEUE, '1, '1);
    add_request(CMD_ENQUEUE, '0, '0);
    add_request(CMD_ENQUEUE, 32'd5, 16'd1);
    add_request(CMD_ENQUEUE, 32'd5, 16'd2);
    add_request(CMD_ENQUEUE, 32'd5, 16'd3);
    for (int i = 0; i < 11; i++) begin
      add_request(CMD_ENQUEUE, (i % 3 == 0) ? 32'd5 : pick_key(), IN_TAG_W'($urandom));
    end
    add_request(CMD_ENQUEUE, 32'd5, 16'hABCD);
    add_request(CMD_LIST, '0, '0);
    add_request(CMD_UNUSED, '0, '0);
    add_request(CMD_DEQUEUE, '1, '1);
    add_request(CMD_DEQUEUE, '0, '0);

    lean = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) lean = $urandom_range(0, 2);
      if (n == 150 || n == 330) add_pause();
      if ($urandom_range(0, 49) == 0) add_request(CMD_UNUSED, $urandom, IN_TAG_W'($urandom));
      enq_share = (lean == 0) ? 75 : (lean == 1) ? 40 : 55;
      roll = $urandom_range(0, 99);
      if (roll < 10) command = CMD_LIST;
      else if (roll < enq_share) command = CMD_ENQUEUE;
      else command = CMD_DEQUEUE;
      add_request(command, pick_key(), IN_TAG_W'($urandom));
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    @(negedge clk_i);
    while (requests.size() != 0 || cmd_ch.valid || pausing) @(negedge clk_i);
    while (awaited.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);

    $display("Sent %0d enqueues (%0d rejected as full), %0d dequeues, %0d lists, %0d ignored.",
             n_enqueue, n_reject, n_dequeue, n_list, n_ignored);
    $display("Checked %0d results; the queue held up to %0d entries.", n_results, max_held);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
